>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the block checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must also hold while reset is asserted
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// shared types and constants of the segment/triangle intersection block
// ----------------------------------------------------------------------------
package sti_pkg;

    // default coordinate width, signed Q16.8
    localparam int COORD_WIDTH_DEF = 24;

    // configuration register index
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } seg_reg_t;

    // result fraction, unsigned Q0.16 with room for exactly one
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    // cyclic neighbors of a vector component, for cross products
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

endpackage

>>> rtl/core/sti_if.sv
// ----------------------------------------------------------------------------
// sti interfaces
// handshake channels of the segment/triangle intersection block
// ----------------------------------------------------------------------------

// triangle input channel
interface sti_tri_if #(
    parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vert_a_x;
    logic signed [COORD_WIDTH-1:0] vert_a_y;
    logic signed [COORD_WIDTH-1:0] vert_a_z;
    logic signed [COORD_WIDTH-1:0] vert_b_x;
    logic signed [COORD_WIDTH-1:0] vert_b_y;
    logic signed [COORD_WIDTH-1:0] vert_b_z;
    logic signed [COORD_WIDTH-1:0] vert_c_x;
    logic signed [COORD_WIDTH-1:0] vert_c_y;
    logic signed [COORD_WIDTH-1:0] vert_c_z;

    modport source (
        output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
               vert_c_x, vert_c_y, vert_c_z,
        input  ready
    );
    modport sink (
        input  valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
               vert_c_x, vert_c_y, vert_c_z,
        output ready
    );
endinterface

// result channel
interface sti_res_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [sti_pkg::FRAC_W-1:0] hit_fraction;

    modport source (output valid, hit, hit_fraction, input ready);
    modport sink   (input valid, hit, hit_fraction, output ready);
endinterface

// configuration write channel
interface sti_cfg_if #(
    parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [sti_pkg::CFG_IDX_W-1:0] index;
    logic [COORD_WIDTH-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/segment_triangle_intersect.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersect
// one-sided segment versus triangle test, one triangle per item
// ----------------------------------------------------------------------------
// The segment is written once through the configuration channel, then triangles
// stream in at one item per clock while the result channel is not stalled. Every item
// gives one result, in order, on the result port, through 22 register stages counting the
// input stage, five arithmetic stages (edge differences, cross products, cross
// differences, split dot-product multiplies, dot sums) followed by a 17-stage
// restoring divider that produces one quotient bit per stage. A stall on the
// result channel freezes the whole pipeline. No hit gives a zero fraction; a
// hit gives floor(t * 65536 / d).
// ----------------------------------------------------------------------------
module segment_triangle_intersect
    import sti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sti_cfg_if.sink   cfg,
    sti_tri_if.sink   tri_in,
    sti_res_if.source result
);

    // arithmetic widths
    localparam int DF   = COORD_WIDTH + 1;      // coordinate difference
    localparam int PW   = 2 * DF;               // difference product
    localparam int CW   = PW + 1;               // cross product component
    localparam int LO_W = CW / 2;               // low split of a cross component
    localparam int HI_W = CW - LO_W;            // signed high split
    localparam int PLW  = DF + LO_W + 1;        // low partial product
    localparam int PHW  = DF + HI_W;            // high partial product
    localparam int DW   = DF + CW + 2;          // dot product
    localparam int NDIV = FRAC_W;               // divider stages

    // segment registers
    logic signed [COORD_WIDTH-1:0] sp_reg [3];
    logic signed [COORD_WIDTH-1:0] sq_reg [3];

    // pipeline advance, whole pipe moves together
    logic adv;
    logic dv_valid_reg [NDIV];

    assign adv          = !dv_valid_reg[NDIV-1] || result.ready;
    assign tri_in.ready = adv;
    assign cfg.ready    = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sp_reg[i] <= '0;
                sq_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (seg_reg_t'(cfg.index))
                REG_START_X: sp_reg[0] <= cfg.data;
                REG_START_Y: sp_reg[1] <= cfg.data;
                REG_START_Z: sp_reg[2] <= cfg.data;
                REG_END_X:   sq_reg[0] <= cfg.data;
                REG_END_Y:   sq_reg[1] <= cfg.data;
                REG_END_Z:   sq_reg[2] <= cfg.data;
                default:     ;
            endcase
        end
    end

    // input vertices as arrays
    logic signed [COORD_WIDTH-1:0] va [3];
    logic signed [COORD_WIDTH-1:0] vb [3];
    logic signed [COORD_WIDTH-1:0] vc [3];

    assign va = '{tri_in.vert_a_x, tri_in.vert_a_y, tri_in.vert_a_z};
    assign vb = '{tri_in.vert_b_x, tri_in.vert_b_y, tri_in.vert_b_z};
    assign vc = '{tri_in.vert_c_x, tri_in.vert_c_y, tri_in.vert_c_z};

    // stage valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            for (int k = 0; k < NDIV; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg    <= tri_in.valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            dv_valid_reg[0] <= s5_valid_reg;
            for (int k = 1; k < NDIV; k++)
            begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
        end
    end

    // stage 1: edge and segment differences
    logic signed [DF-1:0] s1_ab_reg [3];
    logic signed [DF-1:0] s1_ac_reg [3];
    logic signed [DF-1:0] s1_qp_reg [3];
    logic signed [DF-1:0] s1_ap_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_ab_reg[i] <= DF'(vb[i]) - DF'(va[i]);
                s1_ac_reg[i] <= DF'(vc[i]) - DF'(va[i]);
                s1_qp_reg[i] <= DF'(sp_reg[i]) - DF'(sq_reg[i]);
                s1_ap_reg[i] <= DF'(sp_reg[i]) - DF'(va[i]);
            end
        end
    end

    // stage 2: cross product terms for n = ab x ac and e = qp x ap
    logic signed [PW-1:0] s2_np_reg [6];
    logic signed [PW-1:0] s2_ep_reg [6];
    logic signed [DF-1:0] s2_ab_reg [3];
    logic signed [DF-1:0] s2_ac_reg [3];
    logic signed [DF-1:0] s2_qp_reg [3];
    logic signed [DF-1:0] s2_ap_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_np_reg[2*i]   <= s1_ab_reg[NXT[i]] * s1_ac_reg[PRV[i]];
                s2_np_reg[2*i+1] <= s1_ab_reg[PRV[i]] * s1_ac_reg[NXT[i]];
                s2_ep_reg[2*i]   <= s1_qp_reg[NXT[i]] * s1_ap_reg[PRV[i]];
                s2_ep_reg[2*i+1] <= s1_qp_reg[PRV[i]] * s1_ap_reg[NXT[i]];
                s2_ab_reg[i]     <= s1_ab_reg[i];
                s2_ac_reg[i]     <= s1_ac_reg[i];
                s2_qp_reg[i]     <= s1_qp_reg[i];
                s2_ap_reg[i]     <= s1_ap_reg[i];
            end
        end
    end

    // stage 3: cross product components
    logic signed [CW-1:0] s3_n_reg  [3];
    logic signed [CW-1:0] s3_e_reg  [3];
    logic signed [DF-1:0] s3_ab_reg [3];
    logic signed [DF-1:0] s3_ac_reg [3];
    logic signed [DF-1:0] s3_qp_reg [3];
    logic signed [DF-1:0] s3_ap_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_n_reg[i]  <= CW'(s2_np_reg[2*i]) - CW'(s2_np_reg[2*i+1]);
                s3_e_reg[i]  <= CW'(s2_ep_reg[2*i]) - CW'(s2_ep_reg[2*i+1]);
                s3_ab_reg[i] <= s2_ab_reg[i];
                s3_ac_reg[i] <= s2_ac_reg[i];
                s3_qp_reg[i] <= s2_qp_reg[i];
                s3_ap_reg[i] <= s2_ap_reg[i];
            end
        end
    end

    // stage 4: dot product terms, cross component split in low and high halves
    logic signed [PLW-1:0] s4_dlo_reg [3];
    logic signed [PHW-1:0] s4_dhi_reg [3];
    logic signed [PLW-1:0] s4_tlo_reg [3];
    logic signed [PHW-1:0] s4_thi_reg [3];
    logic signed [PLW-1:0] s4_vlo_reg [3];
    logic signed [PHW-1:0] s4_vhi_reg [3];
    logic signed [PLW-1:0] s4_wlo_reg [3];
    logic signed [PHW-1:0] s4_whi_reg [3];

    logic signed [LO_W:0]   n_lo [3];
    logic signed [HI_W-1:0] n_hi [3];
    logic signed [LO_W:0]   e_lo [3];
    logic signed [HI_W-1:0] e_hi [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_lo[i] = $signed({1'b0, s3_n_reg[i][LO_W-1:0]});
            n_hi[i] = s3_n_reg[i][CW-1:LO_W];
            e_lo[i] = $signed({1'b0, s3_e_reg[i][LO_W-1:0]});
            e_hi[i] = s3_e_reg[i][CW-1:LO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_dlo_reg[i] <= s3_qp_reg[i] * n_lo[i];
                s4_dhi_reg[i] <= s3_qp_reg[i] * n_hi[i];
                s4_tlo_reg[i] <= s3_ap_reg[i] * n_lo[i];
                s4_thi_reg[i] <= s3_ap_reg[i] * n_hi[i];
                s4_vlo_reg[i] <= s3_ac_reg[i] * e_lo[i];
                s4_vhi_reg[i] <= s3_ac_reg[i] * e_hi[i];
                s4_wlo_reg[i] <= s3_ab_reg[i] * e_lo[i];
                s4_whi_reg[i] <= s3_ab_reg[i] * e_hi[i];
            end
        end
    end

    // stage 5: dot product sums, w carries ab . e before negation
    logic signed [DW-1:0] s5_d_reg, s5_t_reg, s5_v_reg, s5_abe_reg;
    logic signed [DW-1:0] d_sum, t_sum, v_sum, abe_sum;

    always_comb
    begin
        d_sum   = '0;
        t_sum   = '0;
        v_sum   = '0;
        abe_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            d_sum   = d_sum + (DW'(s4_dhi_reg[i]) <<< LO_W) + DW'(s4_dlo_reg[i]);
            t_sum   = t_sum + (DW'(s4_thi_reg[i]) <<< LO_W) + DW'(s4_tlo_reg[i]);
            v_sum   = v_sum + (DW'(s4_vhi_reg[i]) <<< LO_W) + DW'(s4_vlo_reg[i]);
            abe_sum = abe_sum + (DW'(s4_whi_reg[i]) <<< LO_W) + DW'(s4_wlo_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_d_reg   <= d_sum;
            s5_t_reg   <= t_sum;
            s5_v_reg   <= v_sum;
            s5_abe_reg <= abe_sum;
        end
    end

    // acceptance tests
    logic signed [DW+1:0] w_val;
    logic signed [DW+1:0] vw_sum;
    logic                 hit_now;

    always_comb
    begin
        w_val   = -(DW+2)'(s5_abe_reg);
        vw_sum  = (DW+2)'(s5_v_reg) + w_val;
        hit_now = (s5_d_reg > 0)
               && !s5_t_reg[DW-1] && (s5_t_reg <= s5_d_reg)
               && !s5_v_reg[DW-1] && (s5_v_reg <= s5_d_reg)
               && !w_val[DW+1]
               && (vw_sum <= (DW+2)'(s5_d_reg));
    end

    // divider: stage 0 gives the integer bit, each later stage one fraction bit
    logic              dv_hit_reg [NDIV];
    logic [DW-1:0]     dv_rem_reg [NDIV];
    logic [DW-1:0]     dv_den_reg [NDIV];
    logic [FRAC_W-1:0] dv_q_reg   [NDIV];

    logic [DW-1:0] rem_sh [NDIV];
    logic          rem_ge [NDIV];

    always_comb
    begin
        rem_sh[0] = DW'(s5_t_reg);
        rem_ge[0] = (rem_sh[0] >= DW'(s5_d_reg));
        for (int k = 1; k < NDIV; k++)
        begin
            rem_sh[k] = {dv_rem_reg[k-1][DW-2:0], 1'b0};
            rem_ge[k] = (rem_sh[k] >= dv_den_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_hit_reg[0] <= hit_now;
            dv_den_reg[0] <= DW'(s5_d_reg);
            dv_rem_reg[0] <= rem_ge[0] ? rem_sh[0] - DW'(s5_d_reg) : rem_sh[0];
            dv_q_reg[0]   <= rem_ge[0] ? FRAC_ONE : '0;
            for (int k = 1; k < NDIV; k++)
            begin
                dv_hit_reg[k] <= dv_hit_reg[k-1];
                dv_den_reg[k] <= dv_den_reg[k-1];
                dv_rem_reg[k] <= rem_ge[k] ? rem_sh[k] - dv_den_reg[k-1] : rem_sh[k];
                dv_q_reg[k]   <= dv_q_reg[k-1]
                               | (rem_ge[k] ? (FRAC_ONE >> k) : '0);
            end
        end
    end

    // result
    assign result.valid        = dv_valid_reg[NDIV-1];
    assign result.hit          = dv_hit_reg[NDIV-1];
    assign result.hit_fraction = dv_hit_reg[NDIV-1] ? dv_q_reg[NDIV-1] : '0;

endmodule

>>> rtl/core/sti_check.sv
// ----------------------------------------------------------------------------
// sti_check
// port-level checks of the segment/triangle intersection block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sti_check
    import sti_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic              in_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic              res_hit,
    input logic [FRAC_W-1:0] res_fraction
);

    // a miss carries no fraction
    `ASSERT_CLK(a_miss_zero, clk, rst_n,
        (res_valid && !res_hit) |-> (res_fraction == '0), "miss with nonzero fraction")

    // fraction never exceeds one
    `ASSERT_CLK(a_frac_range, clk, rst_n,
        res_valid |-> (res_fraction <= FRAC_ONE), "fraction above one")

    // stalled result holds
    `ASSERT_CLK(a_res_hold, clk, rst_n,
        (res_valid && !res_ready) |=> (res_valid && $stable(res_hit) && $stable(res_fraction)),
        "stalled result changed")

    // input side follows the output stall
    `ASSERT_CLK(a_in_stall, clk, rst_n,
        (res_valid && !res_ready) |-> !in_ready, "input taken while output stalled")

    // configuration is always taken
    `ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready || !cfg_valid, "configuration write refused")

endmodule

bind segment_triangle_intersect sti_check u_sti_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .in_ready     (tri_in.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_hit      (result.hit),
    .res_fraction (result.hit_fraction)
);

>>> tb/sv/segment_triangle_intersect_test.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersect_test
// streams triangles against a programmed segment and checks each hit result
// against an exact wide-integer prediction, with random gaps and stalls
// ----------------------------------------------------------------------------
module segment_triangle_intersect_test;
    import sti_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int LATENCY   = 22;
    localparam int IDLE_MAX  = 20000;
    localparam int N_RANDOM  = 800;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
    } tri_item_t;

    typedef struct packed {
        logic              hit;
        logic [FRAC_W-1:0] frac;
    } hit_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sti_cfg_if #(.COORD_WIDTH(CW)) cfg ();
    sti_tri_if #(.COORD_WIDTH(CW)) tri_in ();
    sti_res_if result ();

    segment_triangle_intersect #(.COORD_WIDTH(CW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.sink),
        .tri_in (tri_in.sink),
        .result (result.source)
    );

    always #4 clk = ~clk;

    // segment copy held by the predictor
    coord_t    seg [6];
    tri_item_t pending_tris [$];
    hit_item_t expected_hits [$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        burst_on = 1'b1;
    int        burst_left = 0;
    bit        hold_off = 1'b0;
    logic      stall_mode = 1'b0;

    // exact one-sided segment/triangle test
    function automatic hit_item_t predict_hit(tri_item_t t);
        wide_t sp [3], sq [3], a [3], b [3], c [3];
        wide_t ab [3], ac [3], qp [3], n [3], ap [3], e [3];
        wide_t d, tp, v, w;
        hit_item_t r;
        sp = '{wide_t'(seg[0]), wide_t'(seg[1]), wide_t'(seg[2])};
        sq = '{wide_t'(seg[3]), wide_t'(seg[4]), wide_t'(seg[5])};
        a  = '{wide_t'(t.ax), wide_t'(t.ay), wide_t'(t.az)};
        b  = '{wide_t'(t.bx), wide_t'(t.by), wide_t'(t.bz)};
        c  = '{wide_t'(t.cx), wide_t'(t.cy), wide_t'(t.cz)};
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            qp[i] = sp[i] - sq[i];
            ap[i] = sp[i] - a[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            n[i] = ab[(i+1)%3] * ac[(i+2)%3] - ab[(i+2)%3] * ac[(i+1)%3];
            e[i] = qp[(i+1)%3] * ap[(i+2)%3] - qp[(i+2)%3] * ap[(i+1)%3];
        end
        d  = qp[0] * n[0] + qp[1] * n[1] + qp[2] * n[2];
        tp = ap[0] * n[0] + ap[1] * n[1] + ap[2] * n[2];
        v  = ac[0] * e[0] + ac[1] * e[1] + ac[2] * e[2];
        w  = -(ab[0] * e[0] + ab[1] * e[1] + ab[2] * e[2]);
        r = '0;
        if (d > 0 && tp >= 0 && tp <= d && v >= 0 && v <= d && w >= 0 && v + w <= d)
        begin
            r.hit  = 1'b1;
            r.frac = FRAC_W'((tp <<< 16) / d);
        end
        return r;
    endfunction

    // configuration write, only called while the block is idle
    task automatic write_reg(seg_reg_t idx, coord_t val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        seg[idx] = val;
    endtask

    task automatic write_segment(coord_t sx, sy, sz, ex, ey, ez);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_START_Z, sz);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Y, ey);
        write_reg(REG_END_Z, ez);
    endtask

    task automatic drain();
        while (pending_tris.size() != 0 || expected_hits.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic coord_t rand_coord(int span);
        if (span == 0)
            return coord_t'($urandom);
        return coord_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    // triangle around the segment's crossing point, wound either way
    function automatic tri_item_t aimed_tri(int span);
        tri_item_t t;
        coord_t mx, my, mz;
        int k;
        k  = $urandom_range(256);
        mx = coord_t'(seg[0] + ((seg[3] - seg[0]) * k) / 256);
        my = coord_t'(seg[1] + ((seg[4] - seg[1]) * k) / 256);
        mz = coord_t'(seg[2] + ((seg[5] - seg[2]) * k) / 256);
        t.ax = mx + rand_coord(span); t.ay = my + rand_coord(span);
        t.az = mz + rand_coord(span);
        t.bx = mx + rand_coord(span); t.by = my + rand_coord(span);
        t.bz = mz + rand_coord(span);
        t.cx = mx + rand_coord(span); t.cy = my + rand_coord(span);
        t.cz = mz + rand_coord(span);
        return t;
    endfunction

    // triangle driver with bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_in.valid <= 1'b0;
            {tri_in.vert_a_x, tri_in.vert_a_y, tri_in.vert_a_z,
             tri_in.vert_b_x, tri_in.vert_b_y, tri_in.vert_b_z,
             tri_in.vert_c_x, tri_in.vert_c_y, tri_in.vert_c_z} <= '0;
            burst_left   <= 0;
        end
        else
        begin
            if (tri_in.valid && tri_in.ready)
            begin
                expected_hits.push_back(predict_hit(pending_tris.pop_front()));
            end
            if ((!tri_in.valid || tri_in.ready) )
            begin
                if (burst_left == 0)
                begin
                    burst_on   = !burst_on;
                    burst_left <= burst_on ? $urandom_range(40, 1) : $urandom_range(6, 1);
                end
                else
                    burst_left <= burst_left - 1;
                if (burst_on && !hold_off && pending_tris.size() != 0
                    && !(tri_in.valid && tri_in.ready && pending_tris.size() == 0))
                begin
                    tri_in.valid    <= 1'b1;
                    {tri_in.vert_a_x, tri_in.vert_a_y, tri_in.vert_a_z,
                     tri_in.vert_b_x, tri_in.vert_b_y, tri_in.vert_b_z,
                     tri_in.vert_c_x, tri_in.vert_c_y, tri_in.vert_c_z}
                        <= pending_tris[0];
                end
                else
                    tri_in.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        hit_item_t exp_r;
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("result with no triangle outstanding");
                    errors++;
                end
                else
                begin
                    exp_r = expected_hits.pop_front();
                    if (result.hit !== exp_r.hit)
                    begin
                        $error("hit expected %0d actual %0d", exp_r.hit, result.hit);
                        errors++;
                    end
                    if (result.hit_fraction !== exp_r.frac)
                    begin
                        $error("hit_fraction expected %0d actual %0d",
                               exp_r.frac, result.hit_fraction);
                        errors++;
                    end
                end
            end
            if ($urandom_range(63) == 0)
                stall_mode <= ~stall_mode;
            result.ready <= stall_mode ? ($urandom_range(3) == 0) : 1'b1;
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((tri_in.valid && tri_in.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX)
        begin
            $display("FAIL segment_triangle_intersect");
            $finish;
        end
    end

    initial
    begin
        tri_item_t t;
        coord_t big, low;
        big = {1'b0, {(CW-1){1'b1}}};
        low = {1'b1, {(CW-1){1'b0}}};
        for (int i = 0; i < 6; i++) seg[i] = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        repeat (6) @(posedge clk);
        rst_n = 1'b1;

        // zero-length segment at reset: never a hit
        pending_tris.push_back({coord_t'(0), coord_t'(0), coord_t'(0),
                                coord_t'(256), coord_t'(0), coord_t'(0),
                                coord_t'(0), coord_t'(256), coord_t'(0)});
        drain();

        // segment along -z from z=+256 to z=-256
        write_segment(coord_t'(0), coord_t'(0), coord_t'(256),
                      coord_t'(0), coord_t'(0), coord_t'(-256));
        // front face hit at mid
        pending_tris.push_back({coord_t'(-512), coord_t'(-512), coord_t'(0),
                                coord_t'(512), coord_t'(-512), coord_t'(0),
                                coord_t'(0), coord_t'(512), coord_t'(0)});
        // back face: swap winding
        pending_tris.push_back({coord_t'(-512), coord_t'(-512), coord_t'(0),
                                coord_t'(0), coord_t'(512), coord_t'(0),
                                coord_t'(512), coord_t'(-512), coord_t'(0)});
        // plane on the start point, then on the end point
        pending_tris.push_back({coord_t'(-512), coord_t'(-512), coord_t'(256),
                                coord_t'(512), coord_t'(-512), coord_t'(256),
                                coord_t'(0), coord_t'(512), coord_t'(256)});
        pending_tris.push_back({coord_t'(-512), coord_t'(-512), coord_t'(-256),
                                coord_t'(512), coord_t'(-512), coord_t'(-256),
                                coord_t'(0), coord_t'(512), coord_t'(-256)});
        // plane past the end
        pending_tris.push_back({coord_t'(-512), coord_t'(-512), coord_t'(-300),
                                coord_t'(512), coord_t'(-512), coord_t'(-300),
                                coord_t'(0), coord_t'(512), coord_t'(-300)});
        // misses outside the triangle
        pending_tris.push_back({coord_t'(100), coord_t'(100), coord_t'(0),
                                coord_t'(900), coord_t'(100), coord_t'(0),
                                coord_t'(100), coord_t'(900), coord_t'(0)});
        // degenerate triangle: collinear vertices
        pending_tris.push_back({coord_t'(-512), coord_t'(0), coord_t'(0),
                                coord_t'(0), coord_t'(0), coord_t'(0),
                                coord_t'(512), coord_t'(0), coord_t'(0)});
        // parallel: triangle containing the segment direction
        pending_tris.push_back({coord_t'(0), coord_t'(-512), coord_t'(-512),
                                coord_t'(0), coord_t'(512), coord_t'(-512),
                                coord_t'(0), coord_t'(0), coord_t'(512)});
        // field extremes
        pending_tris.push_back({big, big, big, low, low, low, big, low, big});
        pending_tris.push_back({low, low, low, big, low, low, low, big, big});
        pending_tris.push_back({low, low, coord_t'(0), big, low, coord_t'(0),
                                coord_t'(0), big, coord_t'(0)});
        pending_tris.push_back('0);
        pending_tris.push_back('1);
        drain();

        // extreme segment registers
        write_segment(low, low, big, big, big, low);
        for (int i = 0; i < 4; i++) pending_tris.push_back(aimed_tri(0));
        pending_tris.push_back({low, big, coord_t'(0), big, low, coord_t'(0),
                                big, big, coord_t'(0)});
        pending_tris.push_back({big, big, coord_t'(0), big, low, coord_t'(0),
                                low, big, coord_t'(0)});
        drain();

        // random phases; the drain between them also holds the sender until empty
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: write_segment(rand_coord(2048), rand_coord(2048), rand_coord(2048),
                                 rand_coord(2048), rand_coord(2048), rand_coord(2048));
                1: write_segment(rand_coord(0), rand_coord(0), rand_coord(0),
                                 rand_coord(0), rand_coord(0), rand_coord(0));
                2: write_segment(rand_coord(65536), rand_coord(65536), rand_coord(65536),
                                 rand_coord(65536), rand_coord(65536), rand_coord(65536));
                default: write_segment(rand_coord(64), rand_coord(64), rand_coord(64),
                                       rand_coord(64), rand_coord(64), rand_coord(64));
            endcase
            for (int i = 0; i < N_RANDOM / 8; i++)
            begin
                case ($urandom_range(9))
                    0: t = {rand_coord(0), rand_coord(0), rand_coord(0),
                            rand_coord(0), rand_coord(0), rand_coord(0),
                            rand_coord(0), rand_coord(0), rand_coord(0)};
                    1: t = aimed_tri(0);
                    2: t = aimed_tri(16);
                    default: t = aimed_tri(4096);
                endcase
                pending_tris.push_back(t);
            end
            if (phase == 3)
            begin
                // hold the sender until every result is back, then resume
                while (pending_tris.size() > N_RANDOM / 16) @(posedge clk);
                hold_off = 1'b1;
                while (expected_hits.size() != 0 || tri_in.valid) @(posedge clk);
                hold_off = 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("PASS segment_triangle_intersect");
        else
            $display("FAIL segment_triangle_intersect");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/sti_pkg.sv
rtl/core/sti_if.sv
rtl/core/segment_triangle_intersect.sv
rtl/core/sti_check.sv
tb/sv/segment_triangle_intersect_test.sv
